// File: hw/rtl/rttswp_pkg.sv
// Package for the windowed round-trip-time monitor.
// Holds the sizing constants, the microcode word format and the control program.
// No dependencies.
package rttswp_pkg;

  localparam int unsigned BucketSlots   = 8;
  localparam int unsigned WindowMinutes = 5;
  localparam int unsigned IdxW          = $clog2(BucketSlots);
  localparam int unsigned StepW         = 3;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(BucketSlots - 1);

  typedef logic [StepW-1:0] step_t;
  typedef logic [IdxW-1:0]  idx_t;

  // Request kinds
  localparam logic ReqSample = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  // Datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_STATS,
    OP_SCAN_SAMPLE,
    OP_COMMIT,
    OP_SCAN_QUERY,
    OP_EMIT
  } dp_op_e;

  // Sequencing of one microcode step
  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_WAIT_START,
    BR_IF_QUERY,
    BR_IF_MORE
  } br_e;

  typedef struct packed {
    dp_op_e op;
    br_e    br;
    step_t  target;
  } uword_t;

  localparam step_t StepIdle      = 3'd0;
  localparam step_t StepDispatch  = 3'd1;
  localparam step_t StepStats     = 3'd2;
  localparam step_t StepScanSmp   = 3'd3;
  localparam step_t StepCommit    = 3'd4;
  localparam step_t StepScanQry   = 3'd5;
  localparam step_t StepEmit      = 3'd6;

  // Control program
  function automatic uword_t prog_rom(input step_t step);
    uword_t w;
    case (step)
      StepIdle:     w = '{op: OP_LATCH,       br: BR_WAIT_START, target: StepIdle};
      StepDispatch: w = '{op: OP_NOP,         br: BR_IF_QUERY,   target: StepScanQry};
      StepStats:    w = '{op: OP_STATS,       br: BR_NEXT,       target: StepIdle};
      StepScanSmp:  w = '{op: OP_SCAN_SAMPLE, br: BR_IF_MORE,    target: StepScanSmp};
      StepCommit:   w = '{op: OP_COMMIT,      br: BR_JUMP,       target: StepIdle};
      StepScanQry:  w = '{op: OP_SCAN_QUERY,  br: BR_IF_MORE,    target: StepScanQry};
      StepEmit:     w = '{op: OP_EMIT,        br: BR_JUMP,       target: StepIdle};
      default:      w = '{op: OP_NOP,         br: BR_JUMP,       target: StepIdle};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/rtt_stats_windowed_peak.sv
// Windowed round-trip-time monitor: microcoded sequencer and its datapath.
// Depends on rttswp_pkg (constants, microcode format, control program).
//
// Usage: present req_type_i, minute_now_i and rtt_value_i with start high; the
// request is taken at a rising edge where start is high and busy is low.
// An RTT sample (req_type 0) updates min, max, the running average and the
// per-minute peak buckets and returns nothing. A query (req_type 1) returns
// min, max, average and the one-, two- and five-minute peaks on the rtt_*_o
// and peak_*_o ports, marked by valid_o for exactly one cycle.
// Sequence: a sample runs dispatch, statistics, the bucket scan and commit;
// a query runs dispatch, the bucket scan and emit, and its result appears in
// the same cycle that busy falls. The bucket scan reads one slot per cycle
// through a single read port of the bucket store.
// Results sit in output registers and are held until the next query; the
// receiver cannot stall, so valid_o is a plain strobe.
// Reset returns the sequencer to idle, empties all buckets and sets min to
// all ones, max and average to zero.
module rtt_stats_windowed_peak (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [31:0] minute_now_i,
  input  logic [31:0] rtt_value_i,
  output logic        valid_o,
  output logic [31:0] rtt_min_o,
  output logic [31:0] rtt_max_o,
  output logic [31:0] rtt_avg_o,
  output logic [31:0] peak_one_min_o,
  output logic [31:0] peak_two_min_o,
  output logic [31:0] peak_five_min_o
);

  // Sequencer
  rttswp_pkg::step_t  step_q, step_d;
  rttswp_pkg::uword_t uw;
  rttswp_pkg::idx_t   idx_q, idx_d;
  logic               idx_last;

  // Latched request
  logic        req_q;
  logic [31:0] now_q;
  logic [31:0] val_q;

  // Statistics
  logic [31:0] min_q, max_q, avg_q;
  logic [31:0] min_nx;
  logic [32:0] avg_sum;

  // Bucket store
  logic [31:0] bkt_min_q  [rttswp_pkg::BucketSlots];
  logic [31:0] bkt_peak_q [rttswp_pkg::BucketSlots];
  logic [rttswp_pkg::BucketSlots-1:0] used_q;

  // Scan state
  logic               hit_q, free_q, old_vld_q;
  rttswp_pkg::idx_t   hit_idx_q, free_idx_q, old_idx_q;
  logic [31:0]        hit_peak_q, old_tag_q;
  logic [31:0]        p1_q, p2_q, p5_q;

  // Per-slot scan terms
  logic [31:0]        tag, pk;
  logic               used_cur, expire, used_eff, tag_eq;
  logic               in_two, in_five;
  rttswp_pkg::idx_t   slot;

  logic valid_q;
  logic [31:0] out_min_q, out_max_q, out_avg_q, out_p1_q, out_p2_q, out_p5_q;

  assign uw       = rttswp_pkg::prog_rom(step_q);
  assign busy     = (step_q != rttswp_pkg::StepIdle);
  assign idx_last = (idx_q == rttswp_pkg::LastIdx);

  always_comb begin
    step_d = step_q + 3'd1;
    unique case (uw.br)
      rttswp_pkg::BR_NEXT:       step_d = step_q + 3'd1;
      rttswp_pkg::BR_JUMP:       step_d = uw.target;
      rttswp_pkg::BR_WAIT_START: step_d = start ? step_q + 3'd1 : uw.target;
      rttswp_pkg::BR_IF_QUERY:   step_d = (req_q == rttswp_pkg::ReqQuery) ? uw.target
                                                                          : step_q + 3'd1;
      rttswp_pkg::BR_IF_MORE:    step_d = idx_last ? step_q + 3'd1 : uw.target;
      default:                   step_d = rttswp_pkg::StepIdle;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (uw.op == rttswp_pkg::OP_LATCH) begin
      idx_d = '0;
    end else if (uw.op == rttswp_pkg::OP_SCAN_SAMPLE || uw.op == rttswp_pkg::OP_SCAN_QUERY) begin
      idx_d = idx_last ? '0 : idx_q + rttswp_pkg::idx_t'(1);
    end
  end

  // Statistics update terms
  assign min_nx  = (min_q > val_q) ? val_q : min_q;
  assign avg_sum = {1'b0, avg_q} + {1'b0, val_q};

  // Slot terms at the scan index
  assign tag      = bkt_min_q[idx_q];
  assign pk       = bkt_peak_q[idx_q];
  assign used_cur = used_q[idx_q];
  assign expire   = used_cur &&
                    (({1'b0, tag} + 33'(rttswp_pkg::WindowMinutes)) <= {1'b0, now_q});
  assign used_eff = used_cur && !expire;
  assign tag_eq   = (tag == now_q);
  assign in_two   = (({1'b0, tag} + 33'd1) >= {1'b0, now_q});
  assign in_five  = (({1'b0, tag} + 33'(rttswp_pkg::WindowMinutes - 1)) >= {1'b0, now_q});
  assign slot     = free_q ? free_idx_q : old_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= rttswp_pkg::StepIdle;
      idx_q     <= '0;
      min_q     <= '1;
      max_q     <= '0;
      avg_q     <= '0;
      used_q    <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      old_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      step_q  <= step_d;
      idx_q   <= idx_d;
      valid_q <= (uw.op == rttswp_pkg::OP_EMIT);
      case (uw.op)
        rttswp_pkg::OP_LATCH: begin
          hit_q     <= 1'b0;
          free_q    <= 1'b0;
          old_vld_q <= 1'b0;
        end
        rttswp_pkg::OP_STATS: begin
          min_q <= min_nx;
          if (max_q < val_q) max_q <= val_q;
          if (min_nx != '0) begin
            avg_q <= avg_sum[32:1];
          end else begin
            avg_q <= avg_sum[32] ? '1 : avg_sum[31:0];
          end
        end
        rttswp_pkg::OP_SCAN_SAMPLE: begin
          // drop expired buckets as the scan passes them
          used_q[idx_q] <= used_eff;
          if (used_eff && tag_eq && !hit_q) hit_q <= 1'b1;
          if (used_eff && (!old_vld_q || tag < old_tag_q)) old_vld_q <= 1'b1;
          if (!used_eff && !free_q) free_q <= 1'b1;
        end
        rttswp_pkg::OP_COMMIT: begin
          if (!hit_q) used_q[slot] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (uw.op)
      rttswp_pkg::OP_LATCH: begin
        req_q <= req_type_i;
        now_q <= minute_now_i;
        val_q <= rtt_value_i;
        p1_q  <= '0;
        p2_q  <= '0;
        p5_q  <= '0;
      end
      rttswp_pkg::OP_SCAN_SAMPLE: begin
        if (used_eff && tag_eq && !hit_q) begin
          hit_idx_q  <= idx_q;
          hit_peak_q <= pk;
        end
        if (used_eff && (!old_vld_q || tag < old_tag_q)) begin
          old_idx_q <= idx_q;
          old_tag_q <= tag;
        end
        if (!used_eff && !free_q) free_idx_q <= idx_q;
      end
      rttswp_pkg::OP_COMMIT: begin
        if (hit_q) begin
          if (val_q > hit_peak_q) bkt_peak_q[hit_idx_q] <= val_q;
        end else begin
          bkt_min_q[slot]  <= now_q;
          bkt_peak_q[slot] <= val_q;
        end
      end
      rttswp_pkg::OP_SCAN_QUERY: begin
        if (used_cur) begin
          if (tag_eq) p1_q <= pk;
          if (in_two && pk > p2_q) p2_q <= pk;
          if (in_five && pk > p5_q) p5_q <= pk;
        end
      end
      rttswp_pkg::OP_EMIT: begin
        out_min_q <= min_q;
        out_max_q <= max_q;
        out_avg_q <= avg_q;
        out_p1_q  <= p1_q;
        out_p2_q  <= p2_q;
        out_p5_q  <= p5_q;
      end
      default: ;
    endcase
  end

  assign valid_o         = valid_q;
  assign rtt_min_o       = out_min_q;
  assign rtt_max_o       = out_max_q;
  assign rtt_avg_o       = out_avg_q;
  assign peak_one_min_o  = out_p1_q;
  assign peak_two_min_o  = out_p2_q;
  assign peak_five_min_o = out_p5_q;

endmodule
